### sv/yuvp_pkg.sv
package yuvp_pkg;

    localparam int PIX_W  = 24;
    localparam int ACC_W  = 18;
    localparam int COEF_W = 9;

    // BT.601 integer coefficients, scaled by 256, but Y takes 128 for G (BT.601: 129);
    localparam logic signed [COEF_W-1:0] COEF_Y_R = 9'sd66;
    localparam logic signed [COEF_W-1:0] COEF_Y_G = 9'sd128;
    localparam logic signed [COEF_W-1:0] COEF_Y_B = 9'sd25;
    localparam logic signed [COEF_W-1:0] COEF_U_R = -9'sd19;
    localparam logic signed [COEF_W-1:0] COEF_U_G = -9'sd37;
    localparam logic signed [COEF_W-1:0] COEF_U_B = 9'sd56;
    localparam logic signed [COEF_W-1:0] COEF_V_R = 9'sd56;
    localparam logic signed [COEF_W-1:0] COEF_V_G = -9'sd47;
    localparam logic signed [COEF_W-1:0] COEF_V_B = -9'sd9;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = 18'sd128;
    localparam logic [7:0] OFFSET_Y = 8'd16;
    localparam logic [7:0] OFFSET_C = 8'd128;

    // One converted pixel pair; the stream order is U, Y0, V, Y1
    typedef struct packed {
        logic [7:0] y0;
        logic [7:0] u;
        logic [7:0] y1;
        logic [7:0] v;
        logic       user0;
        logic       user1;
        logic       last;
    } yuvp_pair_t;

    function automatic logic signed [ACC_W-1:0] mac3(
        input logic [8:0]               a,
        input logic [8:0]               b,
        input logic [8:0]               c,
        input logic signed [COEF_W-1:0] ka,
        input logic signed [COEF_W-1:0] kb,
        input logic signed [COEF_W-1:0] kc
    );
        logic signed [ACC_W-1:0] sa;
        logic signed [ACC_W-1:0] sb;
        logic signed [ACC_W-1:0] sc;
        sa = $signed(ACC_W'(a));
        sb = $signed(ACC_W'(b));
        sc = $signed(ACC_W'(c));
        return sa * ACC_W'(ka) + sb * ACC_W'(kb) + sc * ACC_W'(kc) + ROUND_BIAS;
    endfunction

    // Floor shift by 8, add offset, clamp to 0..255
    function automatic logic [7:0] sat8(
        input logic signed [ACC_W-1:0] acc,
        input logic [7:0]              offset
    );
        logic signed [ACC_W-1:0] sh;
        logic signed [ACC_W-1:0] v;
        sh = acc >>> 8;
        v  = sh + $signed(ACC_W'(offset));
        if (v < 0) begin
            return 8'd0;
        end else if (v > 255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

endpackage

### sv/rgb_to_yuv422_packer_unit.sv
// RGB to YUV 4:2:2 packer, BT.601 8-bit integer coefficients.
// Slave stream: one RGB pixel per transaction in s_tdata (G [7:0], B [15:8],
// R [23:16]), a user flag in s_tuser, end of frame in s_tlast.
// Master stream: 24-bit words of the byte sequence U Y0 V Y1 ..., earliest
// byte in [7:0]. m_tuser is the OR of the user flags since the previous word;
// one extra word with m_tlast set and m_tuser clear closes every frame and
// carries the leftover bytes, zero filled.
// Throughput: one pixel per cycle sustained while m_tready holds high. The
// front end pairs pixels and computes Y/U/V in one registered stage; a pair
// queue feeds the packer, which emits one word per cycle while not stalled
// (one or two per pair, plus the trailing word at frame end), so output
// averages two thirds of a word per pixel. A frame end makes the packer add
// the trailing word, so a long run of one-pixel frames slows the input.
// The first word of a pair passes the conversion register, the pair queue
// and the output register after the pair's second pixel is accepted.
// When the master side stalls the queue fills, and s_tready drops once the
// queue and the conversion stage are both full.
// Reset (aresetn low, synchronous) empties the queue and clears the held
// pixel, packed bytes and user flag; no clearing pass is needed.
module rgb_to_yuv422_packer_unit
    import yuvp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [PIX_W-1:0] s_tdata,   // pixel: G [7:0], B [15:8], R [23:16]
    input  logic             s_tuser,   // in_user
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // out_word: earliest byte in [7:0]
    output logic             m_tuser,   // out_user
    output logic             m_tlast
);

    logic       q_wr_valid;
    yuvp_pair_t q_wr_data;
    logic       q_full;
    logic       q_rd_valid;
    yuvp_pair_t q_rd_data;
    logic       q_pop;

    yuvp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .q_wr_valid (q_wr_valid),
        .q_wr_data  (q_wr_data),
        .q_full     (q_full)
    );

    yuvp_pair_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .rd_valid (q_rd_valid),
        .rd_data  (q_rd_data),
        .rd_pop   (q_pop)
    );

    yuvp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_rd_valid (q_rd_valid),
        .q_rd_data  (q_rd_data),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

### sv/yuvp_front.sv
module yuvp_front
    import yuvp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [PIX_W-1:0] s_tdata,   // pixel: G [7:0], B [15:8], R [23:16]
    input  logic             s_tuser,   // in_user
    input  logic             s_tlast,
    output logic             q_wr_valid,
    output yuvp_pair_t       q_wr_data,
    input  logic             q_full
);

    logic             held_reg;
    logic [PIX_W-1:0] held_pix_reg;
    logic             held_user_reg;

    logic                    st1_valid_reg;
    logic signed [ACC_W-1:0] y0_acc_reg;
    logic signed [ACC_W-1:0] y1_acc_reg;
    logic signed [ACC_W-1:0] u_acc_reg;
    logic signed [ACC_W-1:0] v_acc_reg;
    logic                    user0_reg;
    logic                    user1_reg;
    logic                    last_reg;

    logic             accept;
    logic             pair_fire;
    logic [PIX_W-1:0] p0;
    logic [PIX_W-1:0] p1;
    logic [8:0]       r0, g0, b0, r1, g1, b1, rs, gs, bs;

    assign s_tready  = !(st1_valid_reg && q_full);
    assign accept    = s_tvalid && s_tready;
    assign pair_fire = accept && (held_reg || s_tlast);

    // Odd frame end pairs the pixel with black
    assign p0 = held_reg ? held_pix_reg : s_tdata;
    assign p1 = held_reg ? s_tdata : '0;

    assign g0 = {1'b0, p0[7:0]};
    assign b0 = {1'b0, p0[15:8]};
    assign r0 = {1'b0, p0[23:16]};
    assign g1 = {1'b0, p1[7:0]};
    assign b1 = {1'b0, p1[15:8]};
    assign r1 = {1'b0, p1[23:16]};
    assign rs = r0 + r1;
    assign gs = g0 + g1;
    assign bs = b0 + b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg      <= 1'b0;
            st1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                held_reg <= !held_reg && !s_tlast;
            end
            if (pair_fire) begin
                st1_valid_reg <= 1'b1;
            end else if (!q_full) begin
                st1_valid_reg <= 1'b0;
            end
        end
        if (accept && !held_reg) begin
            held_pix_reg  <= s_tdata;
            held_user_reg <= s_tuser;
        end
        if (pair_fire) begin
            y0_acc_reg <= mac3(r0, g0, b0, COEF_Y_R, COEF_Y_G, COEF_Y_B);
            y1_acc_reg <= mac3(r1, g1, b1, COEF_Y_R, COEF_Y_G, COEF_Y_B);
            u_acc_reg  <= mac3(rs, gs, bs, COEF_U_R, COEF_U_G, COEF_U_B);
            v_acc_reg  <= mac3(rs, gs, bs, COEF_V_R, COEF_V_G, COEF_V_B);
            user0_reg  <= held_reg ? held_user_reg : s_tuser;
            user1_reg  <= held_reg ? s_tuser : 1'b0;
            last_reg   <= s_tlast;
        end
    end

    assign q_wr_valid      = st1_valid_reg;
    assign q_wr_data.y0    = sat8(y0_acc_reg, OFFSET_Y);
    assign q_wr_data.u     = sat8(u_acc_reg, OFFSET_C);
    assign q_wr_data.y1    = sat8(y1_acc_reg, OFFSET_Y);
    assign q_wr_data.v     = sat8(v_acc_reg, OFFSET_C);
    assign q_wr_data.user0 = user0_reg;
    assign q_wr_data.user1 = user1_reg;
    assign q_wr_data.last  = last_reg;

endmodule

### sv/yuvp_pair_queue.sv
module yuvp_pair_queue
    import yuvp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_valid,
    input  yuvp_pair_t wr_data,
    output logic       full,
    output logic       rd_valid,
    output yuvp_pair_t rd_data,
    input  logic       rd_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    yuvp_pair_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && !full;
    assign do_rd    = rd_pop && rd_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### sv/yuvp_back.sv
module yuvp_back
    import yuvp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_rd_valid,
    input  yuvp_pair_t  q_rd_data,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // out_word: earliest byte in [7:0]
    output logic        m_tuser,    // out_user
    output logic        m_tlast
);

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_TRAIL
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  count_reg, count_next;
    logic [15:0] res_reg, res_next;
    logic        sticky_reg, sticky_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;
    logic        m_tlast_reg, m_tlast_next;
    logic        can_emit;

    assign can_emit = q_rd_valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        res_next      = res_reg;
        sticky_next   = sticky_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        q_pop         = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (can_emit) begin
            m_tvalid_next = 1'b1;
            m_tlast_next  = 1'b0;
            unique case (phase_reg)
                PH_FIRST: begin
                    case (count_reg)
                        2'd0: begin
                            m_tdata_next = {q_rd_data.v, q_rd_data.y0, q_rd_data.u};
                            m_tuser_next = sticky_reg | q_rd_data.user0 | q_rd_data.user1;
                            count_next   = 2'd1;
                            res_next     = {8'h00, q_rd_data.y1};
                            sticky_next  = 1'b0;
                        end
                        2'd1: begin
                            m_tdata_next = {q_rd_data.y0, q_rd_data.u, res_reg[7:0]};
                            m_tuser_next = sticky_reg | q_rd_data.user0;
                            count_next   = 2'd2;
                            res_next     = {q_rd_data.y1, q_rd_data.v};
                            sticky_next  = q_rd_data.user1;
                        end
                        default: begin
                            m_tdata_next = {q_rd_data.u, res_reg};
                            m_tuser_next = sticky_reg | q_rd_data.user0;
                        end
                    endcase
                    if (count_reg[1]) begin
                        phase_next = PH_SECOND;
                    end else if (q_rd_data.last) begin
                        phase_next = PH_TRAIL;
                    end else begin
                        q_pop = 1'b1;
                    end
                end
                PH_SECOND: begin
                    m_tdata_next = {q_rd_data.y1, q_rd_data.v, q_rd_data.y0};
                    m_tuser_next = q_rd_data.user1;
                    count_next   = 2'd0;
                    res_next     = '0;
                    sticky_next  = 1'b0;
                    if (q_rd_data.last) begin
                        phase_next = PH_TRAIL;
                    end else begin
                        phase_next = PH_FIRST;
                        q_pop      = 1'b1;
                    end
                end
                PH_TRAIL: begin
                    // Flush leftover bytes and clear the packer for the next frame
                    m_tdata_next = {8'h00, res_reg};
                    m_tuser_next = 1'b0;
                    m_tlast_next = 1'b1;
                    count_next   = 2'd0;
                    res_next     = '0;
                    sticky_next  = 1'b0;
                    phase_next   = PH_FIRST;
                    q_pop        = 1'b1;
                end
                default: begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FIRST;
            count_reg    <= 2'd0;
            res_reg      <= '0;
            sticky_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            res_reg      <= res_next;
            sticky_reg   <= sticky_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
